>>> design/rgb_downsample_2x2_top_assert.svh
// assertion macros for the rgb downsampler checker
// expects clk and rst_n in the scope of use
`ifndef RGB_DOWNSAMPLE_2X2_TOP_ASSERT_SVH
`define RGB_DOWNSAMPLE_2X2_TOP_ASSERT_SVH

// same-cycle implication
`define RDS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rds check failed");

// next-cycle implication
`define RDS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rds check failed");

`endif

>>> design/rds_pkg.sv
// shared constants, types and channel functions of the rgb 2x2 downsampler
// no dependencies
`timescale 1ns / 1ps

package rds_pkg;

    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;
    localparam int LINE_DEPTH = (MAX_WIDTH + 1) / 2;
    localparam int SLOT_W     = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int WID_W      = $clog2(MAX_WIDTH + 1);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int HGT_W      = $clog2(MAX_HEIGHT + 1);
    localparam int CFG_W      = 13;
    localparam int SAMPLE_W   = 16;
    localparam int PAIR_W     = SAMPLE_W + 1;
    localparam int NCHAN      = 3;
    localparam int ENTRY_W    = NCHAN * PAIR_W;

    typedef enum logic [1:0] {
        CFG_IN_WIDTH     = 2'd0,
        CFG_IN_HEIGHT    = 2'd1,
        CFG_COMBINE_MODE = 2'd2
    } cfg_index_t;

    typedef enum logic {
        MODE_AVERAGE = 1'b0,
        MODE_MAXIMUM = 1'b1
    } mode_t;

    // channel 0 red, 1 green, 2 blue
    typedef logic [NCHAN-1:0][SAMPLE_W-1:0] px_t;
    typedef logic [NCHAN-1:0][PAIR_W-1:0]   pair_t;

    typedef struct packed {
        logic [CFG_W-1:0] in_width;
        logic [CFG_W-1:0] in_height;
        mode_t            combine_mode;
    } cfg_t;

    typedef struct packed {
        logic              we;
        logic              re;
        logic [SLOT_W-1:0] addr;
        pair_t             wdata;
    } ram_req_t;

    typedef struct packed {
        logic  valid;
        logic  use_above;
        logic  use_max;
        logic  row_end;
        logic  frame_end;
        pair_t pair;
    } item_t;

    // horizontal pair: sum or maximum of two samples
    function automatic logic [PAIR_W-1:0] pick_pair(input logic [SAMPLE_W-1:0] a,
                                                   input logic [SAMPLE_W-1:0] b,
                                                   input logic use_max);
        logic [PAIR_W-1:0] res;
        if (use_max)
            res = (a > b) ? PAIR_W'(a) : PAIR_W'(b);
        else
            res = PAIR_W'(a) + PAIR_W'(b);
        return res;
    endfunction

    // vertical combine of two pairs to the final sample
    function automatic logic [SAMPLE_W-1:0] combine_chan(input logic [PAIR_W-1:0] above,
                                                        input logic [PAIR_W-1:0] below,
                                                        input logic use_max);
        logic [PAIR_W:0]     sum;
        logic [PAIR_W-1:0]   mx;
        logic [SAMPLE_W-1:0] res;
        sum = (PAIR_W + 1)'(above) + (PAIR_W + 1)'(below);
        mx  = (above > below) ? above : below;
        if (use_max)
            res = mx[SAMPLE_W-1:0];
        else
            res = sum[PAIR_W:2];
        return res;
    endfunction

endpackage

>>> design/rds_if.sv
// pixel and result stream interfaces of the rgb 2x2 downsampler
// depends on rds_pkg
`timescale 1ns / 1ps

interface rds_pix_if;
    logic                         valid;
    logic                         ready;
    logic [rds_pkg::SAMPLE_W-1:0] in_red;
    logic [rds_pkg::SAMPLE_W-1:0] in_green;
    logic [rds_pkg::SAMPLE_W-1:0] in_blue;

    modport source (output valid, output in_red, output in_green, output in_blue,
                    input ready);
    modport sink (input valid, input in_red, input in_green, input in_blue,
                  output ready);
endinterface

interface rds_res_if;
    logic                         valid;
    logic                         ready;
    logic [rds_pkg::SAMPLE_W-1:0] out_red;
    logic [rds_pkg::SAMPLE_W-1:0] out_green;
    logic [rds_pkg::SAMPLE_W-1:0] out_blue;
    logic                         row_end;
    logic                         frame_end;

    modport source (output valid, output out_red, output out_green, output out_blue,
                    output row_end, output frame_end, input ready);
    modport sink (input valid, input out_red, input out_green, input out_blue,
                  input row_end, input frame_end, output ready);
endinterface

>>> design/rds_ram.sv
// generic single-port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module rds_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                         clk,
    input  logic                                         we,
    input  logic                                         re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [WIDTH-1:0]                             wdata,
    output logic [WIDTH-1:0]                             rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> design/rds_pair_stage.sv
// position tracking, horizontal pairing and line memory access
// depends on rds_pkg
`timescale 1ns / 1ps

module rds_pair_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  rds_pkg::cfg_t     cfg,
    input  logic              accept,
    input  rds_pkg::px_t      px,
    output rds_pkg::ram_req_t ram_req,
    output rds_pkg::item_t    item
);

    logic [rds_pkg::COL_W-1:0] col_reg, col_next;
    logic [rds_pkg::ROW_W-1:0] row_reg, row_next;
    rds_pkg::px_t              held_reg;

    logic [rds_pkg::WID_W-1:0] w;
    logic [rds_pkg::HGT_W-1:0] h;
    logic [31:0]               w_ext, h_ext;
    logic                      col_wrap;
    logic [rds_pkg::COL_W-1:0] c;
    logic [rds_pkg::HGT_W-1:0] r_bump;
    logic [rds_pkg::ROW_W-1:0] r;
    logic                      last_col, last_row;
    logic                      hold, store, emit, use_max;
    rds_pkg::px_t              left, right;
    rds_pkg::pair_t            pair;

    always_comb
    begin
        w_ext = 32'(cfg.in_width);
        h_ext = 32'(cfg.in_height);
        if (w_ext == 32'd0)
            w = rds_pkg::WID_W'(1);
        else if (w_ext > 32'(rds_pkg::MAX_WIDTH))
            w = rds_pkg::WID_W'(rds_pkg::MAX_WIDTH);
        else
            w = rds_pkg::WID_W'(w_ext);
        if (h_ext == 32'd0)
            h = rds_pkg::HGT_W'(1);
        else if (h_ext > 32'(rds_pkg::MAX_HEIGHT))
            h = rds_pkg::HGT_W'(rds_pkg::MAX_HEIGHT);
        else
            h = rds_pkg::HGT_W'(h_ext);

        use_max = (cfg.combine_mode == rds_pkg::MODE_MAXIMUM);

        // geometry may have shrunk since the last pixel
        col_wrap = rds_pkg::WID_W'(col_reg) >= w;
        c        = col_wrap ? '0 : col_reg;
        r_bump   = rds_pkg::HGT_W'(row_reg) + rds_pkg::HGT_W'(col_wrap);
        r        = (r_bump >= h) ? '0 : rds_pkg::ROW_W'(r_bump);

        last_col = (rds_pkg::WID_W'(c) + rds_pkg::WID_W'(1)) == w;
        last_row = (rds_pkg::HGT_W'(r) + rds_pkg::HGT_W'(1)) == h;

        hold  = !c[0] && !last_col;
        store = !hold && !r[0] && !last_row;
        emit  = !hold && !store;

        left  = c[0] ? held_reg : px;
        right = c[0] ? px : '0;
        for (int k = 0; k < rds_pkg::NCHAN; k++)
        begin
            pair[k] = rds_pkg::pick_pair(left[k], right[k], use_max);
        end

        col_next = last_col ? '0 : c + rds_pkg::COL_W'(1);
        if (last_col)
            row_next = last_row ? '0 : r + rds_pkg::ROW_W'(1);
        else
            row_next = r;

        ram_req.we    = accept && store;
        ram_req.re    = accept && emit && r[0];
        ram_req.addr  = rds_pkg::SLOT_W'(c >> 1);
        ram_req.wdata = pair;

        item.valid     = accept && emit;
        item.use_above = r[0];
        item.use_max   = use_max;
        item.row_end   = last_col;
        item.frame_end = last_col && last_row;
        item.pair      = pair;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            held_reg <= '0;
        end
        else if (accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
            if (hold)
            begin
                held_reg <= px;
            end
        end
    end

endmodule

>>> design/rds_combine_stage.sv
// vertical combine with the line memory word and the result output register
// depends on rds_pkg and rds_res_if
`timescale 1ns / 1ps

module rds_combine_stage (
    input  logic             clk,
    input  logic             rst_n,
    input  rds_pkg::item_t   item,
    input  rds_pkg::pair_t   rdata,
    output logic             room,
    rds_res_if.source        result
);

    rds_pkg::item_t              s1_reg, s1_next;
    logic                        out_valid_reg, out_valid_next;
    rds_pkg::px_t                out_px_reg;
    logic                        row_end_reg, frame_end_reg;

    logic                        advance;
    rds_pkg::pair_t              above;
    rds_pkg::px_t                combined;

    always_comb
    begin
        advance = s1_reg.valid && (!out_valid_reg || result.ready);
        room    = !s1_reg.valid || !out_valid_reg || result.ready;

        // last even row pairs with zero from above
        above = s1_reg.use_above ? rdata : '0;
        for (int k = 0; k < rds_pkg::NCHAN; k++)
        begin
            combined[k] = rds_pkg::combine_chan(above[k], s1_reg.pair[k], s1_reg.use_max);
        end

        s1_next = s1_reg;
        if (advance)
            s1_next.valid = 1'b0;
        if (item.valid)
            s1_next = item;

        if (advance)
            out_valid_next = 1'b1;
        else if (result.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_reg        <= s1_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_px_reg    <= combined;
            row_end_reg   <= s1_reg.row_end;
            frame_end_reg <= s1_reg.frame_end;
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.out_red   = out_px_reg[0];
    assign result.out_green = out_px_reg[1];
    assign result.out_blue  = out_px_reg[2];
    assign result.row_end   = row_end_reg;
    assign result.frame_end = frame_end_reg;

endmodule

>>> design/rgb_downsample_2x2_top.sv
// top level of the rgb 2x2 box-filter downsampler
// depends on rds_pkg, rds_if, rds_ram, rds_pair_stage, rds_combine_stage
`timescale 1ns / 1ps

// pixels enter on the pixel channel in raster order, one transfer per pixel,
// and one combined pixel leaves on the result channel for each 2x2 block,
// with row_end on the last pixel of an output row and frame_end on the last
// of the frame. the write port sets in_width (0), in_height (1) and
// combine_mode (2, average or maximum); the user writes it only while the
// stream is idle, which the block does not enforce. throughput is one pixel
// per cycle while pixel.ready is high: each pixel makes at most one access
// to the single-port line memory, a write on even rows or a read on odd rows.
// a result is registered in the combine stage, then in the output register.
// reset clears the position counters and the held left pixel and sets the
// geometry to 1 by 1 in average mode. the line memory is not cleared and
// needs no clearing pass: every odd row reads only entries its even row wrote.
// when the receiver stalls, the output register holds its result and one
// more result may wait in the combine stage; pixel.ready then falls until
// the output register is taken, so nothing is lost.
module rgb_downsample_2x2_top (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [1:0]                cfg_index,
    input  logic [rds_pkg::CFG_W-1:0] cfg_data,
    rds_pix_if.sink                   pixel,
    rds_res_if.source                 result
);

    rds_pkg::cfg_t     cfg_reg;
    rds_pkg::ram_req_t ram_req;
    rds_pkg::item_t    item;
    rds_pkg::px_t      px;
    rds_pkg::pair_t    rdata;
    logic              room;
    logic              accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.in_width     <= rds_pkg::CFG_W'(1);
            cfg_reg.in_height    <= rds_pkg::CFG_W'(1);
            cfg_reg.combine_mode <= rds_pkg::MODE_AVERAGE;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                rds_pkg::CFG_IN_WIDTH:     cfg_reg.in_width <= cfg_data;
                rds_pkg::CFG_IN_HEIGHT:    cfg_reg.in_height <= cfg_data;
                rds_pkg::CFG_COMBINE_MODE: cfg_reg.combine_mode <= rds_pkg::mode_t'(cfg_data[0]);
                default:                   cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign accept      = pixel.valid && room;
    assign pixel.ready = room;
    assign px          = {pixel.in_blue, pixel.in_green, pixel.in_red};

    rds_pair_stage u_pair (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .accept  (accept),
        .px      (px),
        .ram_req (ram_req),
        .item    (item)
    );

    rds_ram #(
        .WIDTH (rds_pkg::ENTRY_W),
        .DEPTH (rds_pkg::LINE_DEPTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (ram_req.we),
        .re    (ram_req.re),
        .addr  (ram_req.addr),
        .wdata (ram_req.wdata),
        .rdata (rdata)
    );

    rds_combine_stage u_combine (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .rdata  (rdata),
        .room   (room),
        .result (result)
    );

endmodule

>>> design/rds_checker.sv
// port-level checks of the rgb 2x2 downsampler, bound to the top level
// depends on rgb_downsample_2x2_top_assert.svh and rgb_downsample_2x2_top
`timescale 1ns / 1ps
`include "rgb_downsample_2x2_top_assert.svh"

module rds_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         pixel_ready,
    input logic                         result_valid,
    input logic                         result_ready,
    input logic [rds_pkg::SAMPLE_W-1:0] out_red,
    input logic [rds_pkg::SAMPLE_W-1:0] out_green,
    input logic [rds_pkg::SAMPLE_W-1:0] out_blue,
    input logic                         row_end,
    input logic                         frame_end
);

    logic [3*rds_pkg::SAMPLE_W+1:0] res_payload;

    assign res_payload = {out_red, out_green, out_blue, row_end, frame_end};

    `RDS_ASSERT_NEXT(a_valid_held, result_valid && !result_ready, result_valid)
    `RDS_ASSERT_NEXT(a_payload_held, result_valid && !result_ready, $stable(res_payload))
    `RDS_ASSERT_NOW(a_frame_end_row_end, result_valid && frame_end, row_end)
    `RDS_ASSERT_NOW(a_ready_when_drained, !result_valid, pixel_ready)

endmodule

bind rgb_downsample_2x2_top rds_checker u_rds_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .pixel_ready  (pixel.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .out_red      (result.out_red),
    .out_green    (result.out_green),
    .out_blue     (result.out_blue),
    .row_end      (result.row_end),
    .frame_end    (result.frame_end)
);

>>> tb/rgb_downsample_2x2_top_tb.sv
// testbench for the rgb 2x2 box-filter downsampler: directed frames, mid-frame
// register changes, random traffic under idling, backpressure and large frames
// depends on rds_pkg, rds_if and rgb_downsample_2x2_top
`timescale 1ns / 1ps

module rgb_downsample_2x2_top_tb;

    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 1000000;

    typedef struct packed {
        logic [rds_pkg::SAMPLE_W-1:0] red;
        logic [rds_pkg::SAMPLE_W-1:0] green;
        logic [rds_pkg::SAMPLE_W-1:0] blue;
        logic                         row_end;
        logic                         frame_end;
    } block_t;

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_we;
    logic [1:0]                cfg_index;
    logic [rds_pkg::CFG_W-1:0] cfg_data;

    rds_pix_if pixel_ch ();
    rds_res_if result_ch ();

    rgb_downsample_2x2_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pixel     (pixel_ch),
        .result    (result_ch)
    );

    // predictor state
    logic [rds_pkg::CFG_W-1:0] width_reg  = 1;
    logic [rds_pkg::CFG_W-1:0] height_reg = 1;
    rds_pkg::mode_t            mode_reg   = rds_pkg::MODE_AVERAGE;
    rds_pkg::pair_t            line_pairs [rds_pkg::LINE_DEPTH];
    rds_pkg::px_t              left_px    = '0;
    int                        col_pos    = 0;
    int                        row_pos    = 0;

    block_t pending_blocks [$];
    int     failures       = 0;
    int     send_idle_pct  = 0;
    int     recv_stall_pct = 0;
    int     hold_left      = 0;
    int     cycle_count    = 0;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    task automatic downsample_pixel(input rds_pkg::px_t px);
        int                           w;
        int                           h;
        int                           c;
        int                           r;
        int                           k;
        logic                         use_max;
        rds_pkg::px_t                 left;
        rds_pkg::px_t                 right;
        rds_pkg::pair_t               pair;
        rds_pkg::pair_t               above;
        rds_pkg::px_t                 outv;
        logic [rds_pkg::PAIR_W-1:0]   mx;
        logic [rds_pkg::PAIR_W:0]     sum;
        block_t                       blk;
        w = (width_reg == 0) ? 1 :
            (width_reg > rds_pkg::MAX_WIDTH) ? rds_pkg::MAX_WIDTH : width_reg;
        h = (height_reg == 0) ? 1 :
            (height_reg > rds_pkg::MAX_HEIGHT) ? rds_pkg::MAX_HEIGHT : height_reg;
        use_max = (mode_reg == rds_pkg::MODE_MAXIMUM);
        if (col_pos >= w)
        begin
            col_pos = 0;
            row_pos++;
        end
        if (row_pos >= h)
            row_pos = 0;
        c = col_pos;
        r = row_pos;
        if (c % 2 == 0 && c != w - 1)
            left_px = px;
        else
        begin
            left  = (c % 2 == 1) ? left_px : px;
            right = (c % 2 == 1) ? px : '0;
            for (k = 0; k < rds_pkg::NCHAN; k++)
            begin
                if (use_max)
                    pair[k] = (left[k] > right[k]) ? {1'b0, left[k]} : {1'b0, right[k]};
                else
                    pair[k] = {1'b0, left[k]} + {1'b0, right[k]};
            end
            if (r % 2 == 0 && r != h - 1)
                line_pairs[(c / 2) % rds_pkg::LINE_DEPTH] = pair;
            else
            begin
                above = (r % 2 == 1) ? line_pairs[(c / 2) % rds_pkg::LINE_DEPTH] : '0;
                for (k = 0; k < rds_pkg::NCHAN; k++)
                begin
                    if (use_max)
                    begin
                        mx = (above[k] > pair[k]) ? above[k] : pair[k];
                        outv[k] = mx[rds_pkg::SAMPLE_W-1:0];
                    end
                    else
                    begin
                        sum = {1'b0, above[k]} + {1'b0, pair[k]};
                        outv[k] = sum[rds_pkg::PAIR_W:2];
                    end
                end
                blk.red       = outv[0];
                blk.green     = outv[1];
                blk.blue      = outv[2];
                blk.row_end   = (c == w - 1);
                blk.frame_end = (c == w - 1) && (r == h - 1);
                pending_blocks.push_back(blk);
            end
        end
        col_pos = c + 1;
        if (col_pos >= w)
        begin
            col_pos = 0;
            row_pos = r + 1;
            if (row_pos >= h)
                row_pos = 0;
        end
    endtask

    function automatic int field_bad(input string name,
                                     input logic [rds_pkg::SAMPLE_W-1:0] want,
                                     input logic [rds_pkg::SAMPLE_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
            return 1;
        end
        return 0;
    endfunction

    // result checker
    always @(posedge clk)
    begin
        block_t want;
        int     bad;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (pending_blocks.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, got %h %h %h %b %b", $time,
                         result_ch.out_red, result_ch.out_green, result_ch.out_blue,
                         result_ch.row_end, result_ch.frame_end);
                failures++;
            end
            else
            begin
                want = pending_blocks.pop_front();
                bad  = field_bad("out_red", want.red, result_ch.out_red)
                     + field_bad("out_green", want.green, result_ch.out_green)
                     + field_bad("out_blue", want.blue, result_ch.out_blue)
                     + field_bad("row_end", rds_pkg::SAMPLE_W'(want.row_end),
                                 rds_pkg::SAMPLE_W'(result_ch.row_end))
                     + field_bad("frame_end", rds_pkg::SAMPLE_W'(want.frame_end),
                                 rds_pkg::SAMPLE_W'(result_ch.frame_end));
                if (bad != 0)
                    failures++;
            end
        end
    end

    // receiver: random stalls, or a counted hold-off
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            result_ch.ready <= 1'b0;
            hold_left--;
        end
        else
            result_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic logic [rds_pkg::SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            default: return rds_pkg::SAMPLE_W'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic rds_pkg::px_t rand_pixel();
        rds_pkg::px_t px;
        px[0] = rand_sample();
        px[1] = rand_sample();
        px[2] = rand_sample();
        return px;
    endfunction

    task automatic send_pixel(input rds_pkg::px_t px);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            pixel_ch.valid <= 1'b0;
            @(posedge clk);
        end
        pixel_ch.valid    <= 1'b1;
        pixel_ch.in_red   <= px[0];
        pixel_ch.in_green <= px[1];
        pixel_ch.in_blue  <= px[2];
        @(posedge clk);
        while (!pixel_ch.ready)
            @(posedge clk);
        downsample_pixel(px);
    endtask

    task automatic send_random_pixels(input int count);
        repeat (count)
            send_pixel(rand_pixel());
    endtask

    task automatic wait_idle();
        pixel_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_blocks.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic write_reg(input rds_pkg::cfg_index_t idx,
                             input logic [rds_pkg::CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            rds_pkg::CFG_IN_WIDTH:     width_reg = val;
            rds_pkg::CFG_IN_HEIGHT:    height_reg = val;
            rds_pkg::CFG_COMBINE_MODE: mode_reg = rds_pkg::mode_t'(val[0]);
            default:                   ;
        endcase
        @(posedge clk);
    endtask

    task automatic set_geometry(input int w, input int h, input rds_pkg::mode_t mode);
        wait_idle();
        write_reg(rds_pkg::CFG_IN_WIDTH, rds_pkg::CFG_W'(w));
        write_reg(rds_pkg::CFG_IN_HEIGHT, rds_pkg::CFG_W'(h));
        write_reg(rds_pkg::CFG_COMBINE_MODE, rds_pkg::CFG_W'(mode));
    endtask

    task automatic test_extremes();
        set_geometry(2, 2, rds_pkg::MODE_AVERAGE);
        repeat (4)
            send_pixel('1);
    endtask

    // odd last column and odd last row pair with zero samples
    task automatic test_odd_edges();
        set_geometry(3, 3, rds_pkg::MODE_AVERAGE);
        send_random_pixels(9);
    endtask

    task automatic test_out_of_range();
        set_geometry(0, 0, rds_pkg::MODE_MAXIMUM);
        send_pixel(rand_pixel());
    endtask

    // stored sums combined under maximum mode
    task automatic test_mode_change();
        set_geometry(2, 2, rds_pkg::MODE_AVERAGE);
        send_pixel({16'hFFFF, 16'h0000, 16'hFFFF});
        send_pixel({16'h0000, 16'hFFFF, 16'hFFFF});
        wait_idle();
        write_reg(rds_pkg::CFG_COMBINE_MODE, rds_pkg::CFG_W'(rds_pkg::MODE_MAXIMUM));
        send_pixel({16'h0000, 16'h0000, 16'hFFFF});
        send_pixel({16'hFFFF, 16'h8001, 16'h0000});
    endtask

    task automatic test_geometry_change();
        set_geometry(4, 4, rds_pkg::MODE_AVERAGE);
        send_random_pixels(2);
        // grow the width inside an even row
        wait_idle();
        write_reg(rds_pkg::CFG_IN_WIDTH, rds_pkg::CFG_W'(6));
        send_random_pixels(4);
        send_random_pixels(3);
        // shrink below the column position: a new row starts
        wait_idle();
        write_reg(rds_pkg::CFG_IN_WIDTH, rds_pkg::CFG_W'(2));
        send_random_pixels(2);
        // shrink below the row position: a new frame starts
        wait_idle();
        write_reg(rds_pkg::CFG_IN_HEIGHT, rds_pkg::CFG_W'(2));
        send_random_pixels(4);
    endtask

    task automatic run_random_phase(input int idle_pct, input int stall_pct,
                                    input int item_goal);
        int             sent;
        int             w;
        int             h;
        int             wr;
        int             hr;
        rds_pkg::mode_t mode;
        sent = 0;
        while (sent < item_goal)
        begin
            case ($urandom_range(0, 9))
                0:       wr = 0;
                1:       wr = $urandom_range(13, 24);
                default: wr = $urandom_range(1, 9);
            endcase
            case ($urandom_range(0, 9))
                0:       hr = 0;
                1:       hr = $urandom_range(7, 10);
                default: hr = $urandom_range(1, 6);
            endcase
            mode = rds_pkg::mode_t'($urandom_range(0, 1));
            w = (wr == 0) ? 1 : wr;
            h = (hr == 0) ? 1 : hr;
            set_geometry(wr, hr, mode);
            send_idle_pct  = idle_pct;
            recv_stall_pct = stall_pct;
            send_random_pixels(w * h);
            sent += w * h;
        end
    endtask

    task automatic test_random_traffic();
        run_random_phase(0, 0, 90);
        run_random_phase(74, 0, 90);
        run_random_phase(0, 74, 90);
        run_random_phase(36, 36, 90);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
    endtask

    // receiver holds off while the sender keeps offering pixels
    task automatic test_backpressure();
        set_geometry(8, 4, rds_pkg::MODE_MAXIMUM);
        hold_left = 200;
        send_random_pixels(32);
    endtask

    // width register above the limit, single-row frame, leading part only
    task automatic test_large_frames();
        set_geometry(8191, 1, rds_pkg::MODE_AVERAGE);
        send_random_pixels(64);
    endtask

    initial
    begin
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = rds_pkg::CFG_IN_WIDTH;
        cfg_data          = '0;
        pixel_ch.valid    = 1'b0;
        pixel_ch.in_red   = '0;
        pixel_ch.in_green = '0;
        pixel_ch.in_blue  = '0;
        result_ch.ready   = 1'b0;
        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_extremes();
        test_odd_edges();
        test_out_of_range();
        test_mode_change();
        test_geometry_change();
        test_random_traffic();
        test_backpressure();
        test_large_frames();

        wait_idle();
        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
